// ===== hdl/gtpf_pkg.sv =====
// Package for the glitch-tolerant pulse finder.
// Holds widths, configuration register indexes, controller states and the
// command/status structs shared by the controller and the datapath.
package gtpf_pkg;

    localparam int IDX_W_DEF = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_SYMBOL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_TOLERANCE    = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_CLOSE,
        ST_WAIT_CLOSE,
        ST_CHK_LAST,
        ST_WAIT_LAST,
        ST_EMIT
    } gtpf_state_t;

    typedef struct packed {
        logic take;        // latch the item and update pulse state
        logic div_close;   // start length check on the closed pulse
        logic load_last;   // capture trailing pulse and start its check
        logic push_close;  // keep closed pulse result if length is valid
        logic push_last;   // keep trailing pulse result if length is valid
        logic clear;       // return pulse state to reset
        logic emit;        // present pending results
    } gtpf_cmd_t;

    typedef struct packed {
        logic close;
        logic last;
        logic seen;
        logic div_done;
        logic pending;
    } gtpf_stat_t;

endpackage

// ===== hdl/gtpf_if.sv =====
// Handshake channel interfaces of the pulse finder: item input, result output
// and configuration write. Depends on gtpf_pkg for field widths.
interface gtpf_item_if;
    logic valid;
    logic ready;
    logic sample;
    logic end_of_capture;

    modport source (output valid, sample, end_of_capture, input ready);
    modport sink (input valid, sample, end_of_capture, output ready);
endinterface

interface gtpf_result_if import gtpf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] pulse_start;
    logic [OUT_W-1:0] pulse_end;
    logic             last_in_run;

    modport source (output valid, pulse_start, pulse_end, last_in_run, input ready);
    modport sink (input valid, pulse_start, pulse_end, last_in_run, output ready);
endinterface

interface gtpf_cfg_if import gtpf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/gtpf_remdiv.sv =====
// Bit-serial restoring divider that returns the remainder of an index-wide
// dividend by a 16-bit nonzero divisor, one dividend bit per cycle. Uses gtpf_pkg.
module gtpf_remdiv
    import gtpf_pkg::*;
#(
    parameter int IW = IDX_W_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IW-1:0]    dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             done,
    output logic [CFG_W-1:0] remainder
);

    localparam int CW = $clog2(IW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [IW-1:0]    dsh_reg, dsh_next;
    logic [CFG_W-1:0] rem_reg, rem_next;

    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, dsh_reg[IW-1]};
        diff  = trial - {1'b0, divisor};
        ge    = trial >= {1'b0, divisor};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dsh_next  = dsh_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(IW - 1);
            dsh_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            dsh_next = {dsh_reg[IW-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsh_reg <= dsh_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/gtpf_datapath.sv =====
// Datapath of the pulse finder: configuration registers, pulse state counters,
// the two result slots and the remainder divider. Uses gtpf_pkg, gtpf_remdiv.
module gtpf_datapath
    import gtpf_pkg::*;
#(
    parameter int IW = IDX_W_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtpf_cmd_t            cmd,
    output gtpf_stat_t           stat,
    input  logic                 sample,
    input  logic                 end_of_capture,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_W-1:0]     pulse_start,
    output logic [OUT_W-1:0]     pulse_end,
    output logic                 last_in_run
);

    localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};

    logic [CFG_W-1:0] spb_reg, spb_next;
    logic [CFG_W-1:0] tol_reg, tol_next;

    logic          seen_reg, seen_next;
    logic [IW-1:0] start_reg, start_next;
    logic [IW-1:0] hlen_reg, hlen_next;
    logic [IW-1:0] gap_reg, gap_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic          close_reg, close_next;
    logic          last_reg, last_next;

    logic [IW-1:0] dlen_reg, dlen_next;
    logic [IW-1:0] r1_start_reg, r1_start_next;
    logic [IW-1:0] r1_end_reg, r1_end_next;
    logic [IW-1:0] r2_start_reg, r2_start_next;
    logic [IW-1:0] r2_end_reg, r2_end_next;
    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;

    logic [CFG_W-1:0] sym;
    logic [IW-1:0]    tol_ext;
    logic             gap_ok;
    logic [IW:0]      merge_sum;
    logic [IW-1:0]    merge_len;
    logic [IW-1:0]    gap_inc;
    logic [IW-1:0]    pos_inc;
    logic [IW:0]      back;
    logic [IW-1:0]    end_close;
    logic [IW-1:0]    end_last;
    logic             div_go;
    logic [IW-1:0]    div_operand;
    logic             div_done;
    logic [CFG_W-1:0] rem;
    logic [CFG_W:0]   sym_minus_rem;
    logic             len_ok;
    logic             pop;

    // A zero symbol length acts as one.
    assign sym     = (spb_reg == '0) ? CFG_W'(1) : spb_reg;
    assign tol_ext = IW'(tol_reg);
    assign gap_ok  = gap_reg <= tol_ext;

    assign merge_sum = {1'b0, hlen_reg} + {1'b0, gap_reg} + (IW+1)'(1);
    assign merge_len = merge_sum[IW] ? IDX_MAX : merge_sum[IW-1:0];
    assign gap_inc   = (gap_reg == IDX_MAX) ? IDX_MAX : gap_reg + 1'b1;
    assign pos_inc   = (pos_reg == IDX_MAX) ? IDX_MAX : pos_reg + 1'b1;

    assign back      = {1'b0, gap_reg} + (IW+1)'(1);
    assign end_close = ({1'b0, pos_reg} >= back) ? pos_reg - back[IW-1:0] : '0;
    assign end_last  = (pos_reg >= gap_reg) ? pos_reg - gap_reg : '0;

    assign div_go      = cmd.div_close | cmd.load_last;
    assign div_operand = cmd.load_last ? hlen_reg : dlen_reg;

    gtpf_remdiv #(
        .IW(IW)
    ) u_remdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_go),
        .dividend  (div_operand),
        .divisor   (sym),
        .done      (div_done),
        .remainder (rem)
    );

    // Valid if within tolerance of n * symbol for some n >= 1.
    assign sym_minus_rem = {1'b0, sym} - {1'b0, rem};
    assign len_ok = ((dlen_reg >= IW'(sym)) && (rem <= tol_reg))
                    || (sym_minus_rem <= {1'b0, tol_reg});

    assign out_valid   = cmd.emit & (v1_reg | v2_reg);
    assign pulse_start = v1_reg ? OUT_W'(r1_start_reg) : OUT_W'(r2_start_reg);
    assign pulse_end   = v1_reg ? OUT_W'(r1_end_reg) : OUT_W'(r2_end_reg);
    assign last_in_run = v1_reg ? ~v2_reg : 1'b1;
    assign pop         = out_valid & out_ready;

    always_comb
    begin
        spb_next = spb_reg;
        tol_next = tol_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_SAMPLES_PER_SYMBOL)
            begin
                spb_next = cfg_data;
            end
            else if (cfg_index == REG_ERROR_TOLERANCE)
            begin
                tol_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        seen_next     = seen_reg;
        start_next    = start_reg;
        hlen_next     = hlen_reg;
        gap_next      = gap_reg;
        pos_next      = pos_reg;
        close_next    = close_reg;
        last_next     = last_reg;
        dlen_next     = dlen_reg;
        r1_start_next = r1_start_reg;
        r1_end_next   = r1_end_reg;
        r2_start_next = r2_start_reg;
        r2_end_next   = r2_end_reg;
        v1_next       = v1_reg;
        v2_next       = v2_reg;

        if (cmd.take)
        begin
            last_next     = end_of_capture;
            close_next    = 1'b0;
            dlen_next     = hlen_reg;
            r1_start_next = start_reg;
            r1_end_next   = end_close;
            if (!seen_reg)
            begin
                if (sample)
                begin
                    seen_next  = 1'b1;
                    start_next = pos_reg;
                    hlen_next  = IW'(1);
                    gap_next   = '0;
                end
            end
            else if (sample)
            begin
                if (gap_ok)
                begin
                    hlen_next = merge_len;
                    gap_next  = '0;
                end
                else
                begin
                    close_next = 1'b1;
                    start_next = pos_reg;
                    hlen_next  = IW'(1);
                    gap_next   = '0;
                end
            end
            else
            begin
                gap_next = gap_inc;
            end
            // Hold the position on the last item; it is still needed for the end index.
            if (!end_of_capture)
            begin
                pos_next = pos_inc;
            end
        end

        if (cmd.load_last)
        begin
            dlen_next     = hlen_reg;
            r2_start_next = start_reg;
            r2_end_next   = end_last;
        end

        if (cmd.push_close)
        begin
            v1_next = len_ok;
        end
        if (cmd.push_last)
        begin
            v2_next = len_ok;
        end

        if (cmd.clear)
        begin
            seen_next  = 1'b0;
            start_next = '0;
            hlen_next  = '0;
            gap_next   = '0;
            pos_next   = '0;
        end

        if (pop)
        begin
            if (v1_reg)
            begin
                v1_next = 1'b0;
            end
            else
            begin
                v2_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg   <= CFG_W'(1);
            tol_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
            hlen_reg  <= '0;
            gap_reg   <= '0;
            pos_reg   <= '0;
            close_reg <= 1'b0;
            last_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            spb_reg   <= spb_next;
            tol_reg   <= tol_next;
            seen_reg  <= seen_next;
            start_reg <= start_next;
            hlen_reg  <= hlen_next;
            gap_reg   <= gap_next;
            pos_reg   <= pos_next;
            close_reg <= close_next;
            last_reg  <= last_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dlen_reg     <= dlen_next;
        r1_start_reg <= r1_start_next;
        r1_end_reg   <= r1_end_next;
        r2_start_reg <= r2_start_next;
        r2_end_reg   <= r2_end_next;
    end

    assign stat.close    = close_reg;
    assign stat.last     = last_reg;
    assign stat.seen     = seen_reg;
    assign stat.div_done = div_done;
    assign stat.pending  = v1_reg | v2_reg;

endmodule

// ===== hdl/gtpf_ctrl.sv =====
// Controller state machine of the pulse finder: sequences item intake, the
// length checks and result delivery. Uses gtpf_pkg.
module gtpf_ctrl
    import gtpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  gtpf_stat_t stat,
    output gtpf_cmd_t  cmd
);

    gtpf_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHK_CLOSE;
                end
            end
            ST_CHK_CLOSE:
            begin
                if (stat.close)
                begin
                    cmd.div_close = 1'b1;
                    state_next    = ST_WAIT_CLOSE;
                end
                else
                begin
                    state_next = ST_CHK_LAST;
                end
            end
            ST_WAIT_CLOSE:
            begin
                if (stat.div_done)
                begin
                    cmd.push_close = 1'b1;
                    state_next     = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST:
            begin
                priority if (stat.last && stat.seen)
                begin
                    cmd.load_last = 1'b1;
                    state_next    = ST_WAIT_LAST;
                end
                else if (stat.last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_WAIT_LAST:
            begin
                if (stat.div_done)
                begin
                    cmd.push_last = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (!stat.pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/glitch_tolerant_pulse_finder_top.sv =====
// Glitch-tolerant pulse finder, top level.
// Item channel (item_in): one line sample and an end-of-capture flag per item.
// Result channel (result_out): start and end index of each valid pulse, with
//   last_in_run set on the final result caused by an item; an item causes
//   zero, one or two results.
// Configuration (cfg): index 0 samples_per_symbol, index 1 error_tolerance;
//   always ready. Write it only while no item is in flight; the block itself
//   leaves this to the user.
// One item is processed at a time. An item that needs no length check and
// causes no result passes through the check-close, check-last and emit states
// before the item channel is ready again. Each length check (on a high sample
// after a long gap, and on end of capture with an open pulse) runs the serial
// remainder divider, which holds the controller until the remainder is done.
// Results are held in two output slots until taken; while result_out.ready is
// low the block holds them and accepts no new item.
// Reset clears the pulse state and sets samples_per_symbol to 1 and
// error_tolerance to 0; no clearing pass follows.
module glitch_tolerant_pulse_finder_top
    import gtpf_pkg::*;
#(
    parameter int INDEX_WIDTH = IDX_W_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    gtpf_item_if.sink     item_in,
    gtpf_result_if.source result_out,
    gtpf_cfg_if.sink      cfg
);

    gtpf_cmd_t  cmd;
    gtpf_stat_t stat;
    logic       item_ready;

    assign item_in.ready = item_ready;
    assign cfg.ready     = 1'b1;

    gtpf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_in.valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    gtpf_datapath #(
        .IW(INDEX_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .sample         (item_in.sample),
        .end_of_capture (item_in.end_of_capture),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_valid      (result_out.valid),
        .out_ready      (result_out.ready),
        .pulse_start    (result_out.pulse_start),
        .pulse_end      (result_out.pulse_end),
        .last_in_run    (result_out.last_in_run)
    );

endmodule

// ===== test/glitch_tolerant_pulse_finder_top_tb.sv =====
// Testbench for glitch_tolerant_pulse_finder_top: drives line samples and
// config writes, predicts each pulse report and checks it field by field.
// Depends on gtpf_pkg and the channel interfaces in hdl/gtpf_if.sv.
module glitch_tolerant_pulse_finder_top_tb;
    import gtpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF    = 4;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          SETTLE      = 100;
    localparam int          HOLD_OFF    = 400;
    localparam logic [63:0] INDEX_MAX   = 64'hFFFF_FFFF;

    typedef struct packed {
        logic sample;
        logic eoc;
    } line_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] first_idx;
        logic [OUT_W-1:0] last_idx;
        logic             last_in_run;
    } pulse_rec_t;

    logic clk;
    logic rst_n;

    gtpf_item_if   item_bus ();
    gtpf_result_if res_bus ();
    gtpf_cfg_if    cfg_bus ();

    glitch_tolerant_pulse_finder_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (res_bus),
        .cfg        (cfg_bus)
    );

    line_item_t line_items[$];
    pulse_rec_t pulses_due[$];

    // predicted register and pulse tracker state
    logic [CFG_W-1:0] sym_len  = 16'd1;
    logic [CFG_W-1:0] tol_len  = 16'd0;
    logic             trk_seen = 1'b0;
    logic [63:0]      trk_start = '0;
    logic [63:0]      trk_high  = '0;
    logic [63:0]      trk_gap   = '0;
    logic [63:0]      trk_pos   = '0;

    logic steady   = 1'b0;
    logic stall_go = 1'b0;
    int   stall_left;
    int   error_count = 0;
    int   cycle_count = 0;
    int   queued      = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] sum;
        sum = a + b;
        return (sum > INDEX_MAX) ? INDEX_MAX : sum;
    endfunction

    // length is near n whole symbols, n >= 1
    function automatic bit length_fits(logic [63:0] len);
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] r;
        s = (sym_len == '0) ? 64'd1 : 64'(sym_len);
        q = len / s;
        r = len % s;
        if (q >= 1 && r <= 64'(tol_len))
            return 1'b1;
        return (s - r) <= 64'(tol_len);
    endfunction

    function automatic pulse_rec_t make_pulse(logic [63:0] first, logic [63:0] last);
        pulse_rec_t rec;
        rec.first_idx   = first[OUT_W-1:0];
        rec.last_idx    = last[OUT_W-1:0];
        rec.last_in_run = 1'b0;
        return rec;
    endfunction

    task automatic predict_pulses(line_item_t it);
        logic [63:0] pos;
        pulse_rec_t  found[$];
        pos = trk_pos;
        if (!trk_seen)
        begin
            if (it.sample)
            begin
                trk_seen  = 1'b1;
                trk_start = pos;
                trk_high  = 64'd1;
                trk_gap   = '0;
            end
        end
        else if (it.sample)
        begin
            if (trk_gap <= 64'(tol_len))
            begin
                // merge the glitch into the open pulse
                trk_high = sat_add(trk_high, sat_add(trk_gap, 64'd1));
                trk_gap  = '0;
            end
            else
            begin
                if (length_fits(trk_high))
                    found.insert(found.size(), make_pulse(trk_start,
                        (pos >= trk_gap + 1) ? pos - trk_gap - 1 : 64'd0));
                trk_start = pos;
                trk_high  = 64'd1;
                trk_gap   = '0;
            end
        end
        else
            trk_gap = sat_add(trk_gap, 64'd1);

        if (it.eoc)
        begin
            if (trk_seen && length_fits(trk_high))
                found.insert(found.size(), make_pulse(trk_start,
                    (pos >= trk_gap) ? pos - trk_gap : 64'd0));
            trk_seen  = 1'b0;
            trk_start = '0;
            trk_high  = '0;
            trk_gap   = '0;
            trk_pos   = '0;
        end
        else
            trk_pos = sat_add(pos, 64'd1);

        if (found.size() != 0)
            found[found.size() - 1].last_in_run = 1'b1;
        foreach (found[i])
            pulses_due.insert(pulses_due.size(), found[i]);
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        line_item_t nxt;
        if (!rst_n)
        begin
            item_bus.valid          <= 1'b0;
            item_bus.sample         <= 1'b0;
            item_bus.end_of_capture <= 1'b0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
                predict_pulses('{sample: item_bus.sample, eoc: item_bus.end_of_capture});
            if (!item_bus.valid || item_bus.ready)
            begin
                if (line_items.size() != 0 && (steady || $urandom_range(99) >= 28))
                begin
                    nxt = line_items.pop_front();
                    item_bus.valid          <= 1'b1;
                    item_bus.sample         <= nxt.sample;
                    item_bus.end_of_capture <= nxt.eoc;
                end
                else
                    item_bus.valid <= 1'b0;
            end
        end
    end

    // receiver hold-off, counted in cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_left <= 0;
        else if (stall_go)
            stall_left <= HOLD_OFF;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_pulses
        pulse_rec_t want;
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (pulses_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected pulse result: start %0d end %0d last %0b",
                        $time, res_bus.pulse_start, res_bus.pulse_end, res_bus.last_in_run);
                end
                else
                begin
                    want = pulses_due.pop_front();
                    if (res_bus.pulse_start !== want.first_idx)
                    begin
                        error_count++;
                        $display("%0t: pulse_start mismatch: expected %0d, got %0d",
                            $time, want.first_idx, res_bus.pulse_start);
                    end
                    if (res_bus.pulse_end !== want.last_idx)
                    begin
                        error_count++;
                        $display("%0t: pulse_end mismatch: expected %0d, got %0d",
                            $time, want.last_idx, res_bus.pulse_end);
                    end
                    if (res_bus.last_in_run !== want.last_in_run)
                    begin
                        error_count++;
                        $display("%0t: last_in_run mismatch: expected %0b, got %0b",
                            $time, want.last_in_run, res_bus.last_in_run);
                    end
                end
            end
            res_bus.ready <= (stall_left == 0) && (steady || $urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("glitch_tolerant_pulse_finder_top_tb: errors");
            $finish;
        end
    end

    task automatic add_item(logic sample, logic eoc);
        line_items.insert(line_items.size(), '{sample: sample, eoc: eoc});
        queued++;
    endtask

    task automatic wait_idle();
        while (line_items.size() != 0 || item_bus.valid || pulses_due.size() != 0
               || !item_bus.ready)
            @(posedge clk);
        // let an item with no result finish before touching the registers
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        if (idx == REG_SAMPLES_PER_SYMBOL)
            sym_len = value;
        else if (idx == REG_ERROR_TOLERANCE)
            tol_len = value;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_config(int sps, int tol);
        wait_idle();
        write_reg(REG_SAMPLES_PER_SYMBOL, CFG_W'(sps));
        write_reg(REG_ERROR_TOLERANCE, CFG_W'(tol));
    endtask

    task automatic queue_noise(int count);
        repeat (count)
            add_item(1'($urandom_range(1)), $urandom_range(19) == 0);
    endtask

    // pulses near whole symbol lengths, with glitches and gaps around the tolerance
    task automatic queue_capture(int sps, int tol, int n_pulses);
        int s;
        int len;
        int glitch_at;
        int glitch_len;
        int g;
        s = (sps == 0) ? 1 : sps;
        for (int p = 0; p < n_pulses; p++)
        begin
            len = $urandom_range(3, 1) * s + int'($urandom_range(2 * tol + 2)) - (tol + 1);
            if (len < 1)
                len = 1;
            if (len > 40)
                len = $urandom_range(40, 1);
            glitch_at  = -1;
            glitch_len = 0;
            if (tol > 0 && len >= 3 && $urandom_range(1) == 1)
            begin
                glitch_len = $urandom_range(tol, 1);
                if (glitch_len > len - 2)
                    glitch_len = len - 2;
                glitch_at = $urandom_range(len - 1 - glitch_len, 1);
            end
            for (int i = 0; i < len; i++)
                add_item(!(i >= glitch_at && i < glitch_at + glitch_len), 1'b0);
            g = ($urandom_range(4) == 0) ? $urandom_range(tol) : tol + $urandom_range(3, 1);
            repeat (g)
                add_item(1'b0, 1'b0);
        end
        add_item(1'($urandom_range(1)), 1'b1);
    endtask

    task automatic random_phase(int sps, int tol, int target, bit shaped);
        int stop_at;
        stop_at = queued + target;
        while (queued < stop_at)
        begin
            if (shaped && $urandom_range(9) < 8)
                queue_capture(sps, tol, $urandom_range(4, 1));
            else
                queue_noise($urandom_range(8, 1));
        end
        // close any capture left open
        add_item(1'($urandom_range(1)), 1'b1);
    endtask

    initial
    begin
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_SAMPLES_PER_SYMBOL;
        cfg_bus.data  = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: end with nothing seen, lone high ending a capture,
        // a closed pulse and a trailing pulse on the same item, trailing lows
        add_item(1'b0, 1'b1);
        add_item(1'b1, 1'b1);
        add_item(1'b1, 1'b0);
        add_item(1'b0, 1'b0);
        add_item(1'b1, 1'b1);
        add_item(1'b1, 1'b0);
        add_item(1'b0, 1'b0);
        add_item(1'b0, 1'b1);

        set_config(4, 1);
        add_item(1'b0, 1'b0);
        repeat (4) add_item(1'b1, 1'b0);
        repeat (3) add_item(1'b0, 1'b0);
        add_item(1'b1, 1'b0);
        add_item(1'b0, 1'b0);
        add_item(1'b1, 1'b0);
        add_item(1'b1, 1'b0);
        repeat (2) add_item(1'b0, 1'b0);
        add_item(1'b1, 1'b0);
        add_item(1'b1, 1'b0);
        add_item(1'b0, 1'b0);
        add_item(1'b0, 1'b1);

        set_config(3, 1);
        random_phase(3, 1, 220, 1'b1);

        // zero symbol length acts as one
        set_config(0, 0);
        random_phase(0, 0, 100, 1'b1);

        // hold off the receiver while items keep coming, then run without gaps
        set_config(5, 2);
        random_phase(5, 2, 220, 1'b1);
        @(posedge clk);
        stall_go <= 1'b1;
        steady   <= 1'b1;
        @(posedge clk);
        stall_go <= 1'b0;

        set_config(65535, 65535);
        @(posedge clk);
        steady <= 1'b0;
        random_phase(65535, 65535, 60, 1'b0);

        set_config(65535, 0);
        random_phase(65535, 0, 40, 1'b0);

        set_config(8, 3);
        random_phase(8, 3, 220, 1'b1);

        wait_idle();
        if (error_count == 0)
            $display("glitch_tolerant_pulse_finder_top_tb: clean");
        else
            $display("glitch_tolerant_pulse_finder_top_tb: errors");
        $finish;
    end

endmodule
